/* hdl/rgb_3x3_convolution_macros.svh */
// assertion macros for the rgb 3x3 convolution block
`ifndef RGB_3X3_CONVOLUTION_MACROS_SVH
`define RGB_3X3_CONVOLUTION_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define RGB3_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("lbl");
// cause at one edge implies effect at the next
`define RGB3_ASSERT_NEXT(lbl, clk, rst_n, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("lbl");
`else
`define RGB3_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define RGB3_ASSERT_NEXT(lbl, clk, rst_n, cause, effect)
`endif
`endif

/* hdl/rgb3_pkg.sv */
// shared types and constants of the rgb 3x3 convolution block
`default_nettype none
package rgb3_pkg;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W  = 24;
  localparam int COEF_W = 16;
  localparam int PROD_W = 25;
  localparam int CFG_W  = 48;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_COEF_TOP    = 3'd0,
    CFG_COEF_MIDDLE = 3'd1,
    CFG_COEF_BOTTOM = 3'd2,
    CFG_WIDTH       = 3'd3,
    CFG_HEIGHT      = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RST_COEF_TOP    = 48'h0;
  localparam logic [CFG_W-1:0] RST_COEF_MIDDLE = 48'h0000_1000_0000;
  localparam logic [CFG_W-1:0] RST_COEF_BOTTOM = 48'h0;
  localparam logic [11:0]      RST_WIDTH       = 12'd640;
  localparam logic [12:0]      RST_HEIGHT      = 13'd480;
endpackage
`default_nettype wire

/* hdl/rgb_3x3_convolution.sv */
// top level of the rgb 3x3 convolution block
// Streaming 3x3 convolution of RGB pixels in raster order.
// Input channel: in_valid/in_stall with red_in, green_in, blue_in, flush.
// Output channel: out_valid/out_stall with red_out, green_out, blue_out,
// end_of_frame. Configuration: cfg_we, cfg_index, cfg_data, written while idle:
// index 0..2 coefficient rows (three signed Q4.12 taps each, left tap in
// low bits), 3 image width, 4 image height.
// Throughput: one pixel per cycle while the output is not stalled. The window is
// nine tap cells in three rows of three; the two previous rows sit in one line
// memory read one column ahead. A result passes the product, row sum and output
// registers after the pixel that completes its window, one row plus one pixel after
// its own pixel. After a frame, image width plus one items drain the last row.
// Flush items inside a frame are dropped without effect.
// Reset clears the counters and the pipeline valid bits; the window and the
// line memory are not cleared, as their stale entries only stand for
// neighbours outside the image.
// When the receiver stalls a full output register, the whole pipeline
// holds and in_stall is raised in the same cycle.
`default_nettype none
`include "rgb_3x3_convolution_macros.svh"
module rgb_3x3_convolution import rgb3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_red_in,
  input  wire logic [7:0]       in_green_in,
  input  wire logic [7:0]       in_blue_in,
  input  wire logic             in_flush,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_red_out,
  output logic [7:0]            out_green_out,
  output logic [7:0]            out_blue_out,
  output logic                  out_end_of_frame,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int OW = $clog2(MAX_HEIGHT + 1);
  localparam int RS_W = PROD_W + 2;
  localparam int TS_W = RS_W + 2;

  typedef struct packed {
    logic       valid;
    logic       eof;
    logic [8:0] use_centre;
  } s1_ctrl_t;

  typedef struct packed {
    logic valid;
    logic eof;
  } ctrl_t;

  // configuration registers
  logic [CFG_W-1:0] coef_r [3];
  logic [11:0]      width_r;
  logic [12:0]      height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= RST_COEF_TOP;
      coef_r[1] <= RST_COEF_MIDDLE;
      coef_r[2] <= RST_COEF_BOTTOM;
      width_r   <= RST_WIDTH;
      height_r  <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_TOP:    coef_r[0] <= cfg_data;
        CFG_COEF_MIDDLE: coef_r[1] <= cfg_data;
        CFG_COEF_BOTTOM: coef_r[2] <= cfg_data;
        CFG_WIDTH:       width_r   <= cfg_data[11:0];
        CFG_HEIGHT:      height_r  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == 13'd0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  // position counters
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [OW-1:0] out_row_r, out_row_nxt;

  logic adv, acc, draining, work, emit, pos_ok, eof_now;
  logic in_last_col, out_last_col, out_last_row;
  pixel_t pix;
  logic [2*PIX_W-1:0] rd_data;
  logic [8:0] use_centre_nxt;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  assign draining     = 32'(in_row_r) >= 32'(h_eff);
  assign in_last_col  = 32'(in_col_r) + 32'd1 >= 32'(w_eff);
  assign out_last_col = 32'(out_col_r) + 32'd1 >= 32'(w_eff);
  assign out_last_row = 32'(out_row_r) + 32'd1 >= 32'(h_eff);

  // pixel position at or beyond one row plus one
  assign pos_ok = (32'(in_row_r) >= 32'd2) ||
                  ((32'(in_row_r) == 32'd1) && (in_col_r != '0)) ||
                  ((in_row_r == '0) && (32'(in_col_r) >= 32'(w_eff) + 32'd1));

  assign work = acc && !(in_flush && !draining) &&
                !(draining && (32'(out_row_r) >= 32'(h_eff)));
  assign emit    = work && pos_ok && (32'(out_row_r) < 32'(h_eff));
  assign eof_now = out_last_row && out_last_col;
  assign pix     = draining ? '0 : {in_blue_in, in_green_in, in_red_in};

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (acc && draining && (32'(out_row_r) >= 32'(h_eff))) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (work) begin
      if (in_last_col) begin
        in_col_nxt = '0;
        if (32'(in_row_r) < 32'(MAX_HEIGHT) + 32'd2) begin
          in_row_nxt = in_row_r + RW'(1);
        end
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (eof_now) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_last_col) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // line memory, read one column ahead
  rgb3_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .wr_en     (work),
    .wr_addr   (in_col_r),
    .wr_data   ({rd_data[PIX_W-1:0], pix}),
    .rd_addr   (in_col_nxt),
    .rd_data_r (rd_data)
  );

  // neighbours outside the frame, columns also checked past a shrunk width
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      use_centre_nxt[k] = ((k / 3 == 0) && (out_row_r == '0)) ||
                          ((k / 3 == 2) && out_last_row) ||
                          ((k % 3 == 0) && ((out_col_r == '0) ||
                            (32'(out_col_r) >= 32'(w_eff) + 32'd1))) ||
                          ((k % 3 == 1) && (32'(out_col_r) >= 32'(w_eff))) ||
                          ((k % 3 == 2) && out_last_col);
    end
  end

  // pipeline control
  s1_ctrl_t s1_r;
  ctrl_t    s2_r, s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= '0;
      s2_r      <= '0;
      s3_r      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid      <= emit;
      s1_r.eof        <= eof_now;
      s1_r.use_centre <= use_centre_nxt;
      s2_r            <= '{valid: s1_r.valid, eof: s1_r.eof};
      s3_r            <= s2_r;
      out_valid       <= s3_r.valid;
    end
  end

  // window cells, fed at the right column of each row
  pixel_t win [9];
  pixel_t row_src [3];
  prod_t  prod [9][3];

  assign row_src[0] = rd_data[2*PIX_W-1:PIX_W];
  assign row_src[1] = rd_data[PIX_W-1:0];
  assign row_src[2] = pix;

  for (genvar k = 0; k < 9; k++) begin : g_cell
    localparam int R = k / 3;
    localparam int C = k % 3;
    pixel_t cell_in;
    if (C == 2) begin : g_edge
      assign cell_in = row_src[R];
    end else begin : g_inner
      assign cell_in = win[k + 1];
    end
    rgb3_cell u_cell (
      .clk        (clk),
      .shift      (work),
      .pix_in     (cell_in),
      .adv        (adv),
      .use_centre (s1_r.use_centre[k]),
      .centre     (win[4]),
      .coef       (coef_t'(coef_r[R][COEF_W*C +: COEF_W])),
      .pix_r      (win[k]),
      .prod_r     (prod[k])
    );
  end

  // row sums
  logic signed [RS_W-1:0] row_sum_r [3][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int ch = 0; ch < 3; ch++) begin
          row_sum_r[r][ch] <= RS_W'(prod[3*r][ch]) + RS_W'(prod[3*r+1][ch]) +
                              RS_W'(prod[3*r+2][ch]);
        end
      end
    end
  end

  // final sum, round half up, clamp to 0..255
  logic signed [TS_W-1:0] tot [3];
  logic [7:0] q [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = TS_W'(row_sum_r[0][ch]) + TS_W'(row_sum_r[1][ch]) +
                TS_W'(row_sum_r[2][ch]) + TS_W'(2048);
      if (tot[ch] <= 0) begin
        q[ch] = 8'd0;
      end else if (tot[ch][TS_W-1:12] > 255) begin
        q[ch] = 8'd255;
      end else begin
        q[ch] = tot[ch][19:12];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_out      <= q[0];
      out_green_out    <= q[1];
      out_blue_out     <= q[2];
      out_end_of_frame <= s3_r.eof;
    end
  end

  // checks
  `RGB3_ASSERT_ALWAYS(a_stall_needs_result, clk, rst_n, !in_stall || out_valid)
  `RGB3_ASSERT_NEXT(a_result_held, clk, rst_n, s3_r.valid && !adv, s3_r.valid)
  `RGB3_ASSERT_NEXT(a_eof_clears, clk, rst_n, emit && eof_now,
                    (in_col_r == '0) && (in_row_r == '0) && (out_row_r == '0))
endmodule
`default_nettype wire

/* hdl/rgb3_line_mem.sv */
// line buffer memory, both previous rows packed in one word, registered read
`default_nettype none
module rgb3_line_mem import rgb3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  wire logic [2*PIX_W-1:0]           wr_data,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic      [2*PIX_W-1:0]           rd_data_r
);
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, new data forwarded on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* hdl/rgb3_cell.sv */
// one window tap: holds a pixel, passes it on, multiplies it by its coefficient
`default_nettype none
module rgb3_cell import rgb3_pkg::*; (
  input  wire logic   clk,
  input  wire logic   shift,
  input  wire pixel_t pix_in,
  input  wire logic   adv,
  input  wire logic   use_centre,
  input  wire pixel_t centre,
  input  wire coef_t  coef,
  output pixel_t      pix_r,
  output prod_t       prod_r [3]
);
  pixel_t p;

  // window pixel moves one column on each transfer that is not dropped
  always_ff @(posedge clk) begin
    if (shift) begin
      pix_r <= pix_in;
    end
  end

  // outside neighbours take the centre pixel
  assign p = use_centre ? centre : pix_r;

  // one product per channel
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_r[ch] <= $signed({1'b0, p[8*ch +: 8]}) * coef;
      end
    end
  end
endmodule
`default_nettype wire

/* bench/tb_rgb_3x3_convolution.sv */
// testbench of the rgb 3x3 convolution block: directed table, extreme taps, then random frames
`timescale 1ns / 100ps
`default_nettype none
module tb_rgb_3x3_convolution import rgb3_pkg::*;;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam int LAT  = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eof;
  } conv_res_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       flush;
    logic       known;
    conv_res_t  res;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_red_in, in_green_in, in_blue_in;
  logic             in_flush;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_red_out, out_green_out, out_blue_out;
  logic             out_end_of_frame;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rgb_3x3_convolution u_dut (.*);

  // shadow of the block state
  logic [47:0] coef_q [3];
  logic [11:0] width_q;
  logic [12:0] height_q;
  pixel_t      prev_line [MAXW];
  pixel_t      prev2_line [MAXW];
  pixel_t      win [9];
  int unsigned in_col, in_row, out_col, out_row;

  conv_res_t expected_q[$];
  bit          failed;
  bit          rx_pause;
  stim_row_t   table_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned eff_w();
    if (width_q == 0) return 1;
    if (width_q > MAXW) return MAXW;
    return width_q;
  endfunction

  function automatic int unsigned eff_h();
    if (height_q == 0) return 1;
    if (height_q > MAXH) return MAXH;
    return height_q;
  endfunction

  function automatic void clear_counts();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic void shadow_reset();
    coef_q[0] = RST_COEF_TOP;
    coef_q[1] = RST_COEF_MIDDLE;
    coef_q[2] = RST_COEF_BOTTOM;
    width_q = RST_WIDTH;
    height_q = RST_HEIGHT;
    foreach (win[i]) win[i] = '0;
    foreach (prev_line[i]) begin
      prev_line[i] = '0;
      prev2_line[i] = '0;
    end
    clear_counts();
  endfunction

  // advance the convolution state by one pixel transfer, return 1 with a result
  function automatic bit conv_step(input logic [7:0] r, g, b, input logic fl,
                                   output conv_res_t res);
    int unsigned w, h, col;
    bit drain, emit, eof;
    pixel_t pix, p;
    longint sum [3];
    longint t, pos;
    int nr, nc;
    logic signed [15:0] k;
    w = eff_w();
    h = eff_h();
    drain = in_row >= h;
    res = '0;
    if (fl && !drain) return 0;
    if (drain && out_row >= h) begin
      clear_counts();
      return 0;
    end
    pix = drain ? '0 : {b, g, r};
    pos = longint'(in_row) * w + in_col;
    emit = pos >= w + 1 && out_row < h;
    col = in_col >= MAXW ? MAXW - 1 : in_col;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = prev2_line[col];
    win[5] = prev_line[col];
    win[8] = pix;
    prev2_line[col] = prev_line[col];
    prev_line[col] = pix;
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < MAXH + 2) in_row++;
    end else in_col++;
    if (!emit) return 0;
    sum = '{0, 0, 0};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        nr = int'(out_row) + i - 1;
        nc = int'(out_col) + j - 1;
        p = win[i*3+j];
        k = coef_q[i][16*j +: 16];
        if (nr < 0 || nc < 0 || nr >= int'(h) || nc >= int'(w)) p = win[4];
        for (int c = 0; c < 3; c++) sum[c] += longint'(p[8*c +: 8]) * longint'(k);
      end
    for (int c = 0; c < 3; c++) begin
      t = sum[c] + 2048;
      t = t > 0 ? (t >>> 12) : 0;
      if (t > 255) t = 255;
      if (c == 0) res.red = t[7:0];
      else if (c == 1) res.green = t[7:0];
      else res.blue = t[7:0];
    end
    eof = out_row + 1 >= h && out_col + 1 >= w;
    res.eof = eof;
    if (eof) clear_counts();
    else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else out_col++;
    return 1;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_COEF_TOP:    coef_q[0] = val;
      CFG_COEF_MIDDLE: coef_q[1] = val;
      CFG_COEF_BOTTOM: coef_q[2] = val;
      CFG_WIDTH:       width_q = val[11:0];
      CFG_HEIGHT:      height_q = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one pixel transfer with prediction; known holds a typed-in expectation
  task automatic send_pixel(input logic [7:0] r, g, b, input logic fl,
                            input bit use_gaps, input bit known = 0,
                            input conv_res_t typed = '0);
    conv_res_t res;
    int gap;
    gap = use_gaps ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_flush <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (conv_step(r, g, b, fl, res)) begin
      if (known && res !== typed)
        $error("directed table row disagrees with predictor");
      expected_q.push_back(res);
    end
    @(negedge clk);
  endtask

  // receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_pause) out_stall <= 1'b0;
      else if ($urandom_range(0, 299) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 30)) @(negedge clk);
      end else out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // result checking
  always @(posedge clk) begin
    conv_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        failed = 1;
      end else begin
        e = expected_q.pop_front();
        if (out_red_out !== e.red) begin
          $error("red_out exp %0d got %0d", e.red, out_red_out); failed = 1;
        end
        if (out_green_out !== e.green) begin
          $error("green_out exp %0d got %0d", e.green, out_green_out); failed = 1;
        end
        if (out_blue_out !== e.blue) begin
          $error("blue_out exp %0d got %0d", e.blue, out_blue_out); failed = 1;
        end
        if (out_end_of_frame !== e.eof) begin
          $error("end_of_frame exp %0d got %0d", e.eof, out_end_of_frame);
          failed = 1;
        end
      end
    end
  end

  // random frame of w x h pixels with random flush noise, then drain
  task automatic random_frame(input int unsigned w, h);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1);
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1);
    end
    for (int unsigned i = 0; i < w + 1; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom_range(0, 3) != 0, 1);
  endtask

  function automatic logic [47:0] rand_coefs();
    logic [47:0] v;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 3))
        0: v[16*j +: 16] = 16'($urandom);
        1: v[16*j +: 16] = 16'($urandom_range(0, 16'h1000));
        2: v[16*j +: 16] = 16'(-$urandom_range(0, 16'h800));
        default: v[16*j +: 16] = 16'($urandom_range(0, 16'h600));
      endcase
    end
    return v;
  endfunction

  initial begin
    int unsigned w, h, sent;
    stim_row_t row;
    failed = 0;
    rx_pause = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_in = '0; in_green_in = '0; in_blue_in = '0; in_flush = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_COEF_TOP; cfg_data = '0;
    shadow_reset();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // identity kernel after reset on a 2x2 frame: each result is its own pixel
    write_reg(CFG_WIDTH, 48'd2);
    write_reg(CFG_HEIGHT, 48'd2);
    table_rows = '{
      '{8'h00, 8'hFF, 8'h80, 1'b1, 1'b0, '0},              // flush inside frame
      '{8'hFF, 8'h00, 8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 8'hFF, 8'h80, 1'b0, 1'b0, '0},
      '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0, '0},
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '{8'hFF, 8'h00, 8'h01, 1'b0}},
      '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'h00, 8'hFF, 8'h80, 1'b0}},
      '{8'hAA, 8'hAA, 8'hAA, 1'b0, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
      '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_pixel(row.red, row.green, row.blue, row.flush, 0, row.known, row.res);
    end
    wait_idle();

    // extreme taps: clamp high and low, single column and single row frames
    write_reg(CFG_COEF_TOP, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_COEF_MIDDLE, 48'h8000_8000_8000);
    write_reg(CFG_COEF_BOTTOM, 48'h7FFF_0000_FFFF);
    write_reg(CFG_WIDTH, 48'd1);
    write_reg(CFG_HEIGHT, 48'd3);
    random_frame(1, 3);
    wait_idle();
    write_reg(CFG_WIDTH, 48'd0);
    write_reg(CFG_HEIGHT, 48'd0);
    random_frame(1, 1);
    send_pixel(8'h55, 8'hAA, 8'h0F, 1'b0, 0);
    send_pixel(8'hF0, 8'h0F, 8'h33, 1'b0, 0);
    wait_idle();
    write_reg(CFG_WIDTH, 48'd5);
    write_reg(CFG_HEIGHT, 48'd1);
    random_frame(5, 1);
    wait_idle();

    // random frames with mostly small sizes
    sent = 0;
    while (sent < 850) begin
      case ($urandom_range(0, 9))
        0: begin w = $urandom_range(20, 40); h = $urandom_range(1, 3); end
        default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 6); end
      endcase
      for (int i = 0; i < 3; i++)
        if ($urandom_range(0, 1)) write_reg(cfg_idx_t'(i), rand_coefs());
      write_reg(CFG_WIDTH, CFG_W'(w));
      write_reg(CFG_HEIGHT, CFG_W'(h));
      random_frame(w, h);
      sent += w * h + w + 1;
      if ($urandom_range(0, 3) == 0) begin
        rx_pause = 1;
        wait_idle();
        rx_pause = 0;
      end else wait_idle();
    end

    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+hdl
hdl/rgb3_pkg.sv
hdl/rgb3_line_mem.sv
hdl/rgb3_cell.sv
hdl/rgb_3x3_convolution.sv
bench/tb_rgb_3x3_convolution.sv
